[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/hcsl_pkg.sv]
// ----------------------------------------------------------------------------
// hcsl_pkg
// shared types and constants of the huffman code lookup unit
// ----------------------------------------------------------------------------
`default_nettype none

package hcsl_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int CODE_WIDTH_DEF  = 32;

    localparam int IN_CODE_W = 32;
    localparam int LEN_W     = 6;
    localparam int SYM_W     = 8;
    localparam int IDX_W     = 8;
    localparam int CFG_W     = 9;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [IDX_W-1:0]     entry_index;
        logic [SYM_W-1:0]     entry_symbol;
        logic [IN_CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]     code_length;
    } t_in_word;

    typedef struct packed {
        logic             found;
        logic [SYM_W-1:0] symbol_out;
    } t_out_word;

    // search token passed from cell to cell
    typedef struct packed {
        logic             tok;
        logic             found;
        logic [SYM_W-1:0] sym;
    } t_link;

endpackage

`default_nettype wire

[rtl/hcsl_cell.sv]
// ----------------------------------------------------------------------------
// hcsl_cell
// one table slot: stores an entry and checks the passing search token
// ----------------------------------------------------------------------------
`default_nettype none

module hcsl_cell
    import hcsl_pkg::*;
#(
    parameter int CELL_IDX   = 0,
    parameter int CODE_WIDTH = CODE_WIDTH_DEF,
    parameter int LIM_W      = 9
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr_en,
    input  wire logic [IDX_W-1:0]      i_wr_index,
    input  wire logic [SYM_W-1:0]      i_wr_symbol,
    input  wire logic [CODE_WIDTH-1:0] i_wr_code,
    input  wire logic [LEN_W-1:0]      i_wr_len,
    input  wire logic [CODE_WIDTH-1:0] i_key_code,
    input  wire logic [LEN_W-1:0]      i_key_len,
    input  wire logic [LIM_W-1:0]      i_limit,
    input  wire t_link                 i_link,
    output t_link                      o_link
);

    localparam logic [LIM_W-1:0] IDX_L = LIM_W'(CELL_IDX);

    logic [SYM_W-1:0]      r_sym;
    logic [CODE_WIDTH-1:0] r_code;
    logic [LEN_W-1:0]      r_len;
    t_link                 r_link;
    t_link                 n_link;
    logic                  w_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (int'(i_wr_index) == CELL_IDX)) begin
            r_sym  <= i_wr_symbol;
            r_code <= i_wr_code;
            r_len  <= i_wr_len;
        end
    end

    assign w_hit = (IDX_L < i_limit) && (r_len == i_key_len) && (r_code == i_key_code);

    always_comb begin
        n_link = i_link;
        if (i_link.tok && !i_link.found && w_hit) begin
            n_link.found = 1'b1;
            n_link.sym   = r_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.tok <= 1'b0;
        end else begin
            r_link.tok <= n_link.tok;
        end
        r_link.found <= n_link.found;
        r_link.sym   <= n_link.sym;
    end

    assign o_link = r_link;

endmodule

`default_nettype wire

[rtl/huffman_code_symbol_lookup_unit.sv]
// ----------------------------------------------------------------------------
// huffman_code_symbol_lookup_unit
// huffman code table held in a row of cells, searched by a walking token
// ----------------------------------------------------------------------------
//  channel | dir | valid / ready              | word
//  in      | in  | i_in_valid / o_in_ready    | t_in_word  (write or lookup)
//  out     | out | o_out_valid / i_out_ready  | t_out_word (one per lookup)
//  cfg     | in  | i_cfg_valid / o_cfg_ready  | entries_in_use, 9 bits
//
//  a write is stored at its accept edge
//  a lookup result is set by the token stepping through the cell row one cell
//  per cycle, then passes the result register and the output register
//  the next word is taken once the result has left the result register, while
//  it may still wait in the output register
//  table contents are not cleared by reset
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_symbol_lookup_unit
    import hcsl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int CODE_WIDTH  = CODE_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_word         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_word             o_out_data,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int LIM_W = $clog2(TABLE_DEPTH + 1);

    logic [CFG_W-1:0]      r_entries;
    logic [LIM_W-1:0]      r_limit;
    logic [LIM_W-1:0]      n_limit;
    logic [CODE_WIDTH-1:0] r_key_code;
    logic [LEN_W-1:0]      r_key_len;
    logic                  r_start;
    logic                  r_scan;
    logic                  r_res_valid;
    t_out_word             r_res;
    logic                  r_out_valid;
    t_out_word             r_out;

    logic                  w_in_take;
    logic                  w_wr;
    logic                  w_lookup;
    logic                  w_out_take;
    logic                  w_tail;
    logic [CODE_WIDTH-1:0] w_code;
    t_link                 w_link [0:TABLE_DEPTH];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !(r_scan || r_res_valid);
    assign w_in_take   = i_in_valid && o_in_ready;
    assign w_wr        = w_in_take && (i_in_data.mode == MODE_WRITE);
    assign w_lookup    = w_in_take && (i_in_data.mode == MODE_LOOKUP);
    assign w_out_take  = r_out_valid && i_out_ready;
    assign w_code      = CODE_WIDTH'(i_in_data.code_bits);
    assign w_tail      = w_link[TABLE_DEPTH].tok;

    always_comb begin
        if (int'(r_entries) > TABLE_DEPTH) begin
            n_limit = LIM_W'(TABLE_DEPTH);
        end else begin
            n_limit = LIM_W'(r_entries);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_entries <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lookup) begin
            r_limit    <= n_limit;
            r_key_code <= w_code;
            r_key_len  <= i_in_data.code_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= 1'b0;
            r_scan      <= 1'b0;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= w_lookup;
            if (w_lookup) begin
                r_scan <= 1'b1;
            end else if (w_tail) begin
                r_scan <= 1'b0;
            end
            if (w_tail) begin
                r_res_valid <= 1'b1;
            end else if (r_res_valid && (!r_out_valid || w_out_take)) begin
                r_res_valid <= 1'b0;
            end
            if (r_res_valid && (!r_out_valid || w_out_take)) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tail) begin
            r_res.found      <= w_link[TABLE_DEPTH].found;
            r_res.symbol_out <= w_link[TABLE_DEPTH].found ? w_link[TABLE_DEPTH].sym : '0;
        end
        if (r_res_valid && (!r_out_valid || w_out_take)) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_link[0] = '{tok: r_start, found: 1'b0, sym: '0};

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        hcsl_cell #(
            .CELL_IDX   (g),
            .CODE_WIDTH (CODE_WIDTH),
            .LIM_W      (LIM_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr_en     (w_wr),
            .i_wr_index  (i_in_data.entry_index),
            .i_wr_symbol (i_in_data.entry_symbol),
            .i_wr_code   (w_code),
            .i_wr_len    (i_in_data.code_length),
            .i_key_code  (r_key_code),
            .i_key_len   (r_key_len),
            .i_limit     (r_limit),
            .i_link      (w_link[g]),
            .o_link      (w_link[g+1])
        );
    end

endmodule

`default_nettype wire

[rtl/hcsl_checker.sv]
// ----------------------------------------------------------------------------
// hcsl_checker
// port-level checks of the huffman code lookup unit
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hcsl_checker
    import hcsl_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire t_in_word         i_in_data,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire t_out_word        o_out_data
);

    logic w_wr_take;
    logic w_lu_take;

    assign w_wr_take = i_in_valid && o_in_ready && (i_in_data.mode == MODE_WRITE);
    assign w_lu_take = i_in_valid && o_in_ready && (i_in_data.mode == MODE_LOOKUP);

    // held result word
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // a miss carries symbol zero
    `ASSERT_IMPLY(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.found, o_out_data.symbol_out == '0)

    // a lookup occupies the unit
    `ASSERT_NEXT(a_lookup_busy, i_clk, i_rst_n, w_lu_take, !o_in_ready)

    // a write never blocks the next word
    `ASSERT_NEXT(a_write_free, i_clk, i_rst_n, w_wr_take, o_in_ready)

endmodule

bind huffman_code_symbol_lookup_unit hcsl_checker u_hcsl_checker (.*);

`default_nettype wire

[verif/tb_huffman_code_symbol_lookup_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_huffman_code_symbol_lookup_unit
// self-checking bench for the huffman code table and its code lookup
//
// fills the code table, sweeps the entries-in-use register through its
// extremes and checks every lookup result against a shadow copy of the
// table. a short directed table covers the corner cases, random traffic
// covers the rest, with random gaps on both channels and one long output
// stall that backs the block up.
// ----------------------------------------------------------------------------

module tb_huffman_code_symbol_lookup_unit;
    import hcsl_pkg::*;

    localparam int DEPTH          = TABLE_DEPTH_DEF;
    localparam int IDLE_PCT       = 7;
    localparam int DRAIN_CYCLES   = DEPTH + 12;
    localparam int HOLD_CYCLES    = 1500;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_WORDS    = 55;
    localparam int PRESSURE_PHASE = 1;
    localparam int STEADY_PHASE   = 4;

    typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        t_in_word         word;
        logic [CFG_W-1:0] cfg;
        logic             typed;
        t_out_word        want;
    } t_dir_row;

    logic             i_clk;
    logic             i_rst_n   = 1'b0;
    logic             in_valid  = 1'b0;
    t_in_word         in_data   = '0;
    logic             out_ready = 1'b1;
    logic             cfg_valid = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             o_in_ready;
    logic             o_out_valid;
    t_out_word        o_out_data;
    logic             o_cfg_ready;

    logic [SYM_W-1:0]     shadow_sym  [DEPTH];
    logic [IN_CODE_W-1:0] shadow_code [DEPTH];
    logic [LEN_W-1:0]     shadow_len  [DEPTH];
    logic [CFG_W-1:0]     shadow_in_use = '0;
    t_out_word            pending_symbols[$];

    bit gaps_on  = 1'b1;
    bit stall_on = 1'b1;
    bit hold_req = 1'b0;
    int err_count = 0;
    int quiet_cycles = 0;

    huffman_code_symbol_lookup_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [IN_CODE_W-1:0] len_mask(input logic [LEN_W-1:0] n);
        return (n >= IN_CODE_W) ? '1 : ((32'h1 << n) - 32'h1);
    endfunction

    // lowest matching slot among those in use wins
    function automatic t_out_word match_code(input logic [IN_CODE_W-1:0] code,
                                             input logic [LEN_W-1:0] len);
        t_out_word res;
        int lim;
        res = '0;
        lim = (shadow_in_use > DEPTH) ? DEPTH : shadow_in_use;
        for (int i = 0; i < lim; i++) begin
            if (shadow_len[i] == len && shadow_code[i] == code) begin
                res.found      = 1'b1;
                res.symbol_out = shadow_sym[i];
                break;
            end
        end
        return res;
    endfunction

    function automatic t_dir_row row_write(input logic [IDX_W-1:0] idx,
                                           input logic [SYM_W-1:0] sym,
                                           input logic [IN_CODE_W-1:0] code,
                                           input logic [LEN_W-1:0] len);
        t_dir_row r;
        r = '0;
        r.kind = ROW_ITEM;
        r.word = '{mode: MODE_WRITE, entry_index: idx, entry_symbol: sym,
                   code_bits: code, code_length: len};
        return r;
    endfunction

    function automatic t_dir_row row_lookup(input logic [IN_CODE_W-1:0] code,
                                            input logic [LEN_W-1:0] len,
                                            input logic typed,
                                            input logic found,
                                            input logic [SYM_W-1:0] sym);
        t_dir_row r;
        r = '0;
        r.kind  = ROW_ITEM;
        r.word  = '{mode: MODE_LOOKUP, entry_index: '0, entry_symbol: '0,
                    code_bits: code, code_length: len};
        r.typed = typed;
        r.want  = '{found: found, symbol_out: sym};
        return r;
    endfunction

    function automatic t_dir_row row_cfg(input logic [CFG_W-1:0] v);
        t_dir_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.cfg  = v;
        return r;
    endfunction

    task automatic send_word(input t_in_word w, input logic typed, input t_out_word want);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge i_clk); while (!(in_valid && o_in_ready));
        if (w.mode == MODE_WRITE) begin
            shadow_sym[w.entry_index]  = w.entry_symbol;
            shadow_code[w.entry_index] = w.code_bits;
            shadow_len[w.entry_index]  = w.code_length;
        end else begin
            pending_symbols.push_back(typed ? want : match_code(w.code_bits, w.code_length));
        end
    endtask

    // register is only written with the block idle
    task automatic set_entries_in_use(input logic [CFG_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_symbols.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!(cfg_valid && o_cfg_ready));
        shadow_in_use = v;
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end else begin
                out_ready <= !(stall_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_symbols.size() == 0) begin
                $display("%0t: unexpected result word found=%0b symbol=%02h",
                         $time, o_out_data.found, o_out_data.symbol_out);
                err_count++;
            end else begin
                exp_word = pending_symbols.pop_front();
                if (o_out_data.found !== exp_word.found) begin
                    $display("%0t: found mismatch expected %0b actual %0b",
                             $time, exp_word.found, o_out_data.found);
                    err_count++;
                end
                if (o_out_data.symbol_out !== exp_word.symbol_out) begin
                    $display("%0t: symbol mismatch expected %02h actual %02h",
                             $time, exp_word.symbol_out, o_out_data.symbol_out);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)
                || (cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_dir_row         dir_rows[$];
        t_dir_row         row;
        t_in_word         w;
        logic [CFG_W-1:0] cfg_plan [NUM_PHASES];
        int               lim;
        int               j;
        int               pick;

        // nothing in use yet
        dir_rows.push_back(row_lookup(32'h0, 6'd0, 1'b1, 1'b0, 8'h00));
        dir_rows.push_back(row_lookup(32'hffff_ffff, 6'd32, 1'b1, 1'b0, 8'h00));
        dir_rows.push_back(row_write(8'd0, 8'hff, 32'hffff_ffff, 6'd32));
        dir_rows.push_back(row_write(8'd1, 8'h00, 32'h0, 6'd0));
        dir_rows.push_back(row_write(8'd2, 8'h3c, 32'h5, 6'd3));
        dir_rows.push_back(row_write(8'd3, 8'hc3, 32'h5, 6'd3));
        dir_rows.push_back(row_write(8'd255, 8'h81, 32'h8000_0001, 6'd63));
        dir_rows.push_back(row_cfg(9'd4));
        dir_rows.push_back(row_lookup(32'hffff_ffff, 6'd32, 1'b1, 1'b1, 8'hff));
        dir_rows.push_back(row_lookup(32'h0, 6'd0, 1'b1, 1'b1, 8'h00));
        // duplicate pair, lower slot wins
        dir_rows.push_back(row_lookup(32'h5, 6'd3, 1'b1, 1'b1, 8'h3c));
        dir_rows.push_back(row_lookup(32'h5, 6'd4, 1'b1, 1'b0, 8'h00));
        // bits above the length still count
        dir_rows.push_back(row_lookup(32'hd, 6'd3, 1'b1, 1'b0, 8'h00));
        dir_rows.push_back(row_lookup(32'h8000_0001, 6'd63, 1'b1, 1'b0, 8'h00));
        dir_rows.push_back(row_cfg(9'd1));
        dir_rows.push_back(row_lookup(32'h5, 6'd3, 1'b1, 1'b0, 8'h00));
        dir_rows.push_back(row_lookup(32'hffff_ffff, 6'd32, 1'b1, 1'b1, 8'hff));
        dir_rows.push_back(row_write(8'd1, 8'h5a, 32'h5, 6'd3));
        dir_rows.push_back(row_cfg(9'd2));
        dir_rows.push_back(row_lookup(32'h5, 6'd3, 1'b0, 1'b0, 8'h00));
        dir_rows.push_back(row_lookup(32'h0, 6'd0, 1'b0, 1'b0, 8'h00));

        cfg_plan[0] = 9'd256;
        cfg_plan[1] = 9'd511;
        cfg_plan[2] = 9'd0;
        cfg_plan[3] = 9'd1;
        cfg_plan[4] = 9'd255;
        cfg_plan[5] = 9'($urandom_range(2, 511));
        cfg_plan[6] = 9'($urandom_range(2, 255));
        cfg_plan[7] = 9'd256;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.kind == ROW_CFG) begin
                set_entries_in_use(row.cfg);
            end else begin
                send_word(row.word, row.typed, row.want);
            end
        end

        // fill every slot before any wide lookup
        for (int s = 0; s < DEPTH; s++) begin
            w.mode         = MODE_WRITE;
            w.entry_index  = IDX_W'(s);
            w.entry_symbol = SYM_W'($urandom);
            w.code_length  = LEN_W'($urandom_range(1, 32));
            w.code_bits    = $urandom & len_mask(w.code_length);
            send_word(w, 1'b0, '0);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_entries_in_use(cfg_plan[p]);
            gaps_on  = (p != STEADY_PHASE);
            stall_on = (p != STEADY_PHASE);
            if (p == PRESSURE_PHASE) begin
                hold_req = 1'b1;
            end
            lim = (shadow_in_use > DEPTH) ? DEPTH : shadow_in_use;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                w.entry_index  = IDX_W'($urandom);
                w.entry_symbol = SYM_W'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    w.mode = MODE_WRITE;
                    if ($urandom_range(0, 9) != 0) begin
                        w.code_length = LEN_W'($urandom_range(1, 32));
                        w.code_bits   = $urandom & len_mask(w.code_length);
                    end else begin
                        w.code_length = LEN_W'($urandom_range(0, 63));
                        w.code_bits   = $urandom;
                    end
                end else begin
                    w.mode = MODE_LOOKUP;
                    j = (lim > 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, DEPTH - 1);
                    w.code_bits   = shadow_code[j];
                    w.code_length = shadow_len[j];
                    if (pick >= 88) begin
                        w.code_length = LEN_W'($urandom_range(0, 63));
                        w.code_bits   = $urandom;
                    end else if (pick >= 76) begin
                        // near miss on one code bit or on the length
                        if ($urandom_range(0, 1) == 0) begin
                            w.code_bits = w.code_bits ^ (32'h1 << $urandom_range(0, 31));
                        end else begin
                            w.code_length = w.code_length + ($urandom_range(0, 1) ? 6'd1 : 6'h3f);
                        end
                    end
                end
                send_word(w, 1'b0, '0);
            end
        end

        gaps_on  = 1'b1;
        stall_on = 1'b1;
        in_valid <= 1'b0;
        while (pending_symbols.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
